### hw/rtl/dhkv_pkg.sv
// Shared types and codes for the double-hash key/value table.
package dhkv_pkg;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        key;
    logic signed [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] found_value;
    logic [9:0]         entry_count;
  } rsp_t;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_IGNORE = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_SECOND = 8'd1;

  localparam logic [31:0] MULT_FIRST_RST  = 32'd151;
  localparam logic [31:0] MULT_SECOND_RST = 32'd163;

  localparam int ENT_W = 2 + 32 + 64;

endpackage

### hw/rtl/double_hash_key_value_table.sv
// Open-addressed key/value table with double hashing over one entry memory.
// Requests come in on in_valid/in_ready/in_data: insert or overwrite, search,
// or delete a 32-bit key. Each request yields exactly one result on
// out_valid/out_ready/out_data (status, found value, live entry count).
// Hash multipliers are written on cfg_valid/cfg_ready with cfg_index and
// cfg_data; the user must write them only while no request is in flight,
// as the block itself does not enforce this. Each request is hashed (key
// and multipliers reduced modulo TABLE_SIZE, multiplied, reduced again),
// then probed for 1 to TABLE_SIZE probes, each a memory read and then an
// evaluation, then finished. An ignored action skips hashing and probing.
// One request is worked at a time; in_ready rises with out_valid, as the
// result moves into the output register. The entry memory has one write
// port and one registered read port.
// After reset a clearing pass marks every slot empty, one slot per cycle;
// in_ready stays low until the pass ends.
// When the receiver stalls, the result holds in the output register and the
// block stalls in its finish step until the output register frees.
module double_hash_key_value_table #(
  parameter int TABLE_SIZE = 1021
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dhkv_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dhkv_pkg::rsp_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dhkv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam logic [IDX_W:0]   N_EXT  = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] N_LAST = IDX_W'(TABLE_SIZE - 1);
  localparam logic [31:0]      N_W32  = 32'(TABLE_SIZE);
  localparam logic [31:0]      RECIP  = 32'((64'd1 << 32) / 64'(TABLE_SIZE));

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_QA    = 4'd2;
  localparam logic [3:0] ST_QB    = 4'd3;
  localparam logic [3:0] ST_QC    = 4'd4;
  localparam logic [3:0] ST_PROD  = 4'd5;
  localparam logic [3:0] ST_READ  = 4'd6;
  localparam logic [3:0] ST_EVAL  = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  logic [3:0]           state_r;
  logic [31:0]          mult1_r, mult2_r;
  dhkv_pkg::req_t       req_r;
  logic [31:0]          red_x_r [3];
  logic [31:0]          q_r [3];
  logic [IDX_W:0]       red_t_r [3];
  logic [IDX_W-1:0]     res_r [3];
  logic                 pass_r;
  logic [IDX_W-1:0]     slot_r;
  logic [IDX_W:0]       stride_r;
  logic [IDX_W-1:0]     probe_cnt_r;
  logic [IDX_W-1:0]     clr_cnt_r;
  logic                 hit_r, free_f_r;
  logic [IDX_W-1:0]     hit_slot_r, free_slot_r;
  logic [63:0]          hit_val_r;
  logic [CNT_W-1:0]     count_r;
  logic                 out_valid_r;
  dhkv_pkg::rsp_t       out_r;

  logic [dhkv_pkg::ENT_W-1:0] mem [TABLE_SIZE];
  logic [dhkv_pkg::ENT_W-1:0] rd_q;
  logic                       we;
  logic [IDX_W-1:0]           wr_addr;
  logic [dhkv_pkg::ENT_W-1:0] wr_data;

  logic [1:0]  rd_mark;
  logic [31:0] rd_key;
  logic [63:0] rd_val;
  assign rd_mark = rd_q[dhkv_pkg::ENT_W-1 -: 2];
  assign rd_key  = rd_q[95:64];
  assign rd_val  = rd_q[63:0];

  // Three-lane reduction modulo TABLE_SIZE: estimate the quotient by a
  // reciprocal multiply (low by at most one), subtract, correct once.
  logic [63:0]    qa_prod [3];
  logic [31:0]    qb_diff [3];
  logic [IDX_W:0] qc_red [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qa_prod[j] = 64'(red_x_r[j]) * 64'(RECIP);
      qb_diff[j] = red_x_r[j] - q_r[j] * N_W32;
      qc_red[j]  = (red_t_r[j] >= N_EXT) ? red_t_r[j] - N_EXT : red_t_r[j];
    end
  end

  logic [IDX_W:0]   step_sum;
  logic [IDX_W-1:0] slot_nxt;
  always_comb begin
    step_sum = {1'b0, slot_r} + stride_r;
    if (step_sum >= N_EXT) step_sum = step_sum - N_EXT;
    slot_nxt = step_sum[IDX_W-1:0];
  end

  logic fin_go;
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Finish step: result and write-back; also the clearing writes after reset.
  dhkv_pkg::rsp_t   rsp;
  logic [CNT_W-1:0] count_nxt;
  always_comb begin
    rsp.status      = dhkv_pkg::STAT_NOT_FOUND;
    rsp.found_value = '1;
    count_nxt       = count_r;
    we              = 1'b0;
    wr_addr         = clr_cnt_r;
    wr_data         = {dhkv_pkg::MARK_EMPTY, 96'd0};
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
    end else if (fin_go) begin
      case (req_r.action)
        dhkv_pkg::ACT_INSERT: begin
          if (hit_r) begin
            we = 1'b1;
            wr_addr = hit_slot_r;
            wr_data = {dhkv_pkg::MARK_LIVE, req_r.key, req_r.value};
            rsp.status = dhkv_pkg::STAT_OK;
          end else if (free_f_r) begin
            we = 1'b1;
            wr_addr = free_slot_r;
            wr_data = {dhkv_pkg::MARK_LIVE, req_r.key, req_r.value};
            count_nxt = count_r + 1'b1;
            rsp.status = dhkv_pkg::STAT_OK;
          end else begin
            rsp.status = dhkv_pkg::STAT_FULL;
          end
        end
        dhkv_pkg::ACT_SEARCH: begin
          if (hit_r) begin
            rsp.status = dhkv_pkg::STAT_OK;
            rsp.found_value = hit_val_r;
          end
        end
        dhkv_pkg::ACT_DELETE: begin
          if (hit_r) begin
            we = 1'b1;
            wr_addr = hit_slot_r;
            wr_data = {dhkv_pkg::MARK_TOMB, req_r.key, req_r.value};
            if (count_r != '0) count_nxt = count_r - 1'b1;
            rsp.status = dhkv_pkg::STAT_OK;
          end
        end
        default: ;
      endcase
    end
    rsp.entry_count = 10'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_q <= mem[slot_r];
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      mult1_r     <= dhkv_pkg::MULT_FIRST_RST;
      mult2_r     <= dhkv_pkg::MULT_SECOND_RST;
      slot_r      <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == dhkv_pkg::CFG_MULT_FIRST)  mult1_r <= cfg_data;
        if (cfg_index == dhkv_pkg::CFG_MULT_SECOND) mult2_r <= cfg_data;
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == N_LAST) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_r      <= in_data;
            hit_r      <= 1'b0;
            free_f_r   <= 1'b0;
            red_x_r[0] <= in_data.key;
            red_x_r[1] <= mult1_r;
            red_x_r[2] <= mult2_r;
            pass_r     <= 1'b0;
            state_r    <= (in_data.action == dhkv_pkg::ACT_IGNORE) ? ST_FIN : ST_QA;
          end
        end
        ST_QA: begin
          for (int j = 0; j < 3; j++) q_r[j] <= qa_prod[j][63:32];
          state_r <= ST_QB;
        end
        ST_QB: begin
          for (int j = 0; j < 3; j++) red_t_r[j] <= qb_diff[j][IDX_W:0];
          state_r <= ST_QC;
        end
        ST_QC: begin
          for (int j = 0; j < 3; j++) res_r[j] <= qc_red[j][IDX_W-1:0];
          if (!pass_r) begin
            state_r <= ST_PROD;
          end else begin
            slot_r      <= qc_red[0][IDX_W-1:0];
            stride_r    <= {1'b0, qc_red[1][IDX_W-1:0]} + (IDX_W + 1)'(1);
            probe_cnt_r <= '0;
            state_r     <= ST_READ;
          end
        end
        // Multiply the reduced key by each reduced multiplier, then reduce again.
        ST_PROD: begin
          red_x_r[0] <= 32'(res_r[0]) * 32'(res_r[1]);
          red_x_r[1] <= 32'(res_r[0]) * 32'(res_r[2]);
          red_x_r[2] <= '0;
          pass_r     <= 1'b1;
          state_r    <= ST_QA;
        end
        ST_READ: state_r <= ST_EVAL;
        ST_EVAL: begin
          if (rd_mark == dhkv_pkg::MARK_EMPTY) begin
            if (!free_f_r) begin
              free_f_r    <= 1'b1;
              free_slot_r <= slot_r;
            end
            state_r <= ST_FIN;
          end else if (rd_mark == dhkv_pkg::MARK_LIVE && rd_key == req_r.key) begin
            hit_r      <= 1'b1;
            hit_slot_r <= slot_r;
            hit_val_r  <= rd_val;
            state_r    <= ST_FIN;
          end else begin
            if (rd_mark == dhkv_pkg::MARK_TOMB && !free_f_r) begin
              free_f_r    <= 1'b1;
              free_slot_r <= slot_r;
            end
            if (probe_cnt_r == N_LAST) begin
              state_r <= ST_FIN;
            end else begin
              probe_cnt_r <= probe_cnt_r + 1'b1;
              slot_r      <= slot_nxt;
              state_r     <= ST_READ;
            end
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_r       <= rsp;
            out_valid_r <= 1'b1;
            count_r     <= count_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### test/tb_double_hash_key_value_table.sv
// Testbench for the double-hash key/value table: predictor, driver, monitor and checks.
module tb_double_hash_key_value_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = 1021;
  localparam int LIMIT = 20000000;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  dhkv_pkg::req_t in_data;
  dhkv_pkg::rsp_t out_data;
  logic [dhkv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  double_hash_key_value_table #(.TABLE_SIZE(N)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic [31:0] mult_a, mult_b;
  logic [1:0]  mark_q [N];
  logic [31:0] key_q [N];
  logic [63:0] val_q [N];
  int unsigned live_q;

  dhkv_pkg::req_t pending_reqs[$];
  dhkv_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int full_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  bit in_acc = 0;
  longint cycles = 0;

  function automatic int slot_at(logic [31:0] k, int i);
    longint unsigned h1, h2;
    h1 = ({32'd0, k} * {32'd0, mult_a}) % N;
    h2 = ({32'd0, k} * {32'd0, mult_b}) % N;
    return int'((h1 + longint'(i) * (h2 + 1)) % N);
  endfunction

  function automatic dhkv_pkg::rsp_t predict_table(dhkv_pkg::req_t r);
    dhkv_pkg::rsp_t o;
    int hit, tomb, empty, s;
    hit = -1;
    tomb = -1;
    empty = -1;
    o.status = dhkv_pkg::STAT_NOT_FOUND;
    o.found_value = -64'sd1;
    if (r.action != dhkv_pkg::ACT_IGNORE) begin
      for (int i = 0; i < N; i++) begin
        s = slot_at(r.key, i);
        if (mark_q[s] == dhkv_pkg::MARK_EMPTY) begin
          empty = s;
          break;
        end
        if (mark_q[s] == dhkv_pkg::MARK_LIVE) begin
          if (key_q[s] == r.key) begin
            hit = s;
            break;
          end
        end else if (tomb < 0) begin
          tomb = s;
        end
      end
      case (r.action)
        dhkv_pkg::ACT_INSERT: begin
          if (hit >= 0) begin
            val_q[hit] = r.value;
            o.status = dhkv_pkg::STAT_OK;
          end else if (tomb >= 0 || empty >= 0) begin
            s = (tomb >= 0) ? tomb : empty;
            mark_q[s] = dhkv_pkg::MARK_LIVE;
            key_q[s] = r.key;
            val_q[s] = r.value;
            live_q++;
            o.status = dhkv_pkg::STAT_OK;
          end else begin
            o.status = dhkv_pkg::STAT_FULL;
          end
        end
        dhkv_pkg::ACT_SEARCH: begin
          if (hit >= 0) begin
            o.found_value = val_q[hit];
            o.status = dhkv_pkg::STAT_OK;
          end
        end
        dhkv_pkg::ACT_DELETE: begin
          if (hit >= 0) begin
            mark_q[hit] = dhkv_pkg::MARK_TOMB;
            if (live_q > 0) live_q--;
            o.status = dhkv_pkg::STAT_OK;
          end
        end
        default: ;
      endcase
    end
    o.entry_count = live_q[9:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  // driver: advance only after the current item transferred
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_acc) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor and prediction on accepted transfers
  always @(posedge clk) begin
    cycles++;
    in_acc = rst_n && in_valid && in_ready;
    if (in_acc) begin
      expected_rsps.push_back(predict_table(in_data));
      accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data.status), 64'd0);
      end else begin
        dhkv_pkg::rsp_t e;
        e = expected_rsps.pop_front();
        if (out_data.status != e.status)
          report_mismatch("status", 64'(out_data.status), 64'(e.status));
        if (out_data.found_value !== e.found_value)
          report_mismatch("found_value", out_data.found_value, e.found_value);
        if (out_data.entry_count != e.entry_count)
          report_mismatch("entry_count", 64'(out_data.entry_count), 64'(e.entry_count));
        if (e.status == dhkv_pkg::STAT_FULL) full_seen++;
      end
      checked++;
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("double_hash_key_value_table verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [dhkv_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == dhkv_pkg::CFG_MULT_FIRST) mult_a = v;
    else mult_b = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic dhkv_pkg::req_t make_req(logic [1:0] a, logic [31:0] k, logic [63:0] v);
    dhkv_pkg::req_t r;
    r.action = a;
    r.key = k;
    r.value = v;
    return r;
  endfunction

  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // keys drawn from a small pool so hits, overwrites and tombstones recur
  task automatic queue_random(int count, int pool);
    logic [1:0] a;
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: a = dhkv_pkg::ACT_INSERT;
        4, 5, 6: a = dhkv_pkg::ACT_SEARCH;
        7, 8: a = dhkv_pkg::ACT_DELETE;
        default: a = ($urandom_range(3) == 0) ? dhkv_pkg::ACT_IGNORE : dhkv_pkg::ACT_SEARCH;
      endcase
      k = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(pool - 1)) * 32'd7919;
      pending_reqs.push_back(make_req(a, k, rand_value()));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mult_a = dhkv_pkg::MULT_FIRST_RST;
    mult_b = dhkv_pkg::MULT_SECOND_RST;
    live_q = 0;
    for (int i = 0; i < N; i++) begin
      mark_q[i] = dhkv_pkg::MARK_EMPTY;
      key_q[i] = '0;
      val_q[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every action, overwrite, delete miss, tombstone reuse
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_SEARCH, 32'd0, 64'd5));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_INSERT, 32'd0, 64'h7fff_ffff_ffff_ffff));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_INSERT, 32'hffff_ffff,
                                    64'h8000_0000_0000_0000));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_SEARCH, 32'hffff_ffff, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_INSERT, 32'd0, 64'hffff_ffff_ffff_ffff));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_SEARCH, 32'd0, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_DELETE, 32'd1021, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_INSERT, 32'd1021, 64'd11));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_DELETE, 32'd0, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_SEARCH, 32'd1021, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_INSERT, 32'd2042, 64'd22));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_SEARCH, 32'd0, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_DELETE, 32'd0, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_IGNORE, 32'd1021, 64'hffff_ffff_ffff_ffff));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_SEARCH, 32'h5555_5555,
                                    64'h5555_5555_5555_5555));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_INSERT, 32'haaaa_aaaa,
                                    64'haaaa_aaaa_aaaa_aaaa));
    drain();

    queue_random(200, 64);
    drain();

    // extreme multipliers: an all-ones first multiplier and stride one for every key
    write_reg(dhkv_pkg::CFG_MULT_FIRST, 32'hffff_ffff);
    write_reg(dhkv_pkg::CFG_MULT_SECOND, 32'd1021);
    send_idle_pct = 82;
    queue_random(200, 48);
    drain();

    write_reg(dhkv_pkg::CFG_MULT_FIRST, 32'd1);
    write_reg(dhkv_pkg::CFG_MULT_SECOND, 32'hffff_ffff);
    send_idle_pct = 0;
    recv_stall_pct = 82;
    queue_random(200, 48);
    drain();

    // long receiver hold-off while the sender keeps offering
    recv_stall_pct = 0;
    hold_off = 1;
    queue_random(60, 48);
    fork
      begin
        int held;
        held = 0;
        while (held < 2000) begin
          @(posedge clk);
          held++;
        end
        hold_off = 0;
      end
    join
    drain();

    write_reg(dhkv_pkg::CFG_MULT_FIRST, 32'd2654435761);
    write_reg(dhkv_pkg::CFG_MULT_SECOND, 32'd40503);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    queue_random(300, 300);
    drain();

    // zero stride: keys congruent to one all land on one slot, so a second
    // such key walks the full chain and finds no room
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(dhkv_pkg::CFG_MULT_FIRST, 32'd1);
    write_reg(dhkv_pkg::CFG_MULT_SECOND, 32'd1020);
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_INSERT, 32'd1, 64'd101));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_INSERT, 32'd1022, 64'd102));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_SEARCH, 32'd2043, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_DELETE, 32'd1, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_INSERT, 32'd2043, 64'd103));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_SEARCH, 32'd2043, 64'd0));
    pending_reqs.push_back(make_req(dhkv_pkg::ACT_SEARCH, 32'd1022, 64'd0));
    drain();

    write_reg(dhkv_pkg::CFG_MULT_FIRST, dhkv_pkg::MULT_FIRST_RST);
    write_reg(dhkv_pkg::CFG_MULT_SECOND, dhkv_pkg::MULT_SECOND_RST);
    queue_random(300, 64);
    drain();

    $display("covered %0d requests over several multiplier settings, %0d results checked,",
             accepted, checked);
    $display("%0d table-full replies, idle and stall phases plus a long output hold-off",
             full_seen);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("double_hash_key_value_table verification clean");
    end else begin
      $display("double_hash_key_value_table verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dhkv_pkg.sv
hw/rtl/double_hash_key_value_table.sv
test/tb_double_hash_key_value_table.sv
